// ----- design/fcfs_pkg.sv -----
`timescale 1ns / 1ps

package fcfs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int BURST_BITS  = 16;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W       = 8;
  localparam int BURST_IN_W = 16;
  localparam int TIME_W     = 32;

  localparam int IN_DATA_W  = ((ID_W + BURST_IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 2 * TIME_W + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [0:0] {
    ACT_ARRIVE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_DONE      = 2'd0,
    KIND_FULL      = 2'd1,
    KIND_ZERO      = 2'd2
  } kind_t;

endpackage

// ----- design/fcfs_job_scheduler.sv -----
`timescale 1ns / 1ps

// First-come-first-served job scheduler.
// Input channel (in_*): one word per event. in_tuser is the action: an arrival
// pushes (job_id, burst_length) onto a queue of QUEUE_DEPTH jobs, a tick serves
// the head job for one time unit and then advances the time counter, which
// saturates at its maximum.
// Result channel (out_*): at most one word per input word. out_tuser is the kind:
// a completion (id, start tick, finish tick), a rejection because the queue is
// full, or a rejection because the burst is zero (times read zero on rejection).
// Accepted arrivals and ticks that finish no job give no word.
// Timing: a word is taken into an input register, and the queue update and the
// result are worked out in one pass from that register into the output register,
// so a result passes through the input register and then the output register.
// One input word is accepted every cycle while the result channel is not stalled;
// the single pass over the head entry and its service counter sets that figure.
// Reset (rst_n low, synchronous) empties the queue and clears time and service
// count. When the receiver holds out_tready low the result stays in the output
// register, the input register fills, and in_tready falls until the result is
// taken.

module fcfs_job_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fcfs_pkg::IN_DATA_W-1:0]     in_tdata,   // job_id, burst_length
  input  logic                               in_tuser,   // action
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fcfs_pkg::OUT_DATA_W-1:0]    out_tdata,  // done_id, start_time, finish_time
  output fcfs_pkg::kind_t                    out_tuser   // kind
);

  import fcfs_pkg::*;

  logic                    in_vld_r;
  action_t                 in_act_r;
  logic [ID_W-1:0]         in_id_r;
  logic [BURST_IN_W-1:0]   in_burst_r;

  logic [ID_W-1:0]         queued_ids_r    [QUEUE_DEPTH];
  logic [BURST_BITS-1:0]   queued_bursts_r [QUEUE_DEPTH];

  logic [PTR_W-1:0]        head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0]        tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0]        fill_count_r, fill_count_nxt;
  logic [TIME_W-1:0]       now_time_r, now_time_nxt;
  logic [BURST_BITS-1:0]   served_ticks_r, served_ticks_nxt;
  logic [TIME_W-1:0]       head_start_r, head_start_nxt;

  logic                    out_vld_r, out_vld_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic [TIME_W-1:0]       out_start_r, out_start_nxt;
  logic [TIME_W-1:0]       out_fin_r, out_fin_nxt;

  logic                    fire;
  logic                    push;
  logic [BURST_BITS-1:0]   burst_m;
  logic [BURST_BITS-1:0]   served_inc;
  logic [TIME_W-1:0]       start_sel;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign burst_m   = BURST_BITS'(in_burst_r);
  assign served_inc = served_ticks_r + BURST_BITS'(1);
  assign start_sel = (served_ticks_r == '0) ? now_time_r : head_start_r;

  always_comb begin
    head_ptr_nxt     = head_ptr_r;
    tail_ptr_nxt     = tail_ptr_r;
    fill_count_nxt   = fill_count_r;
    now_time_nxt     = now_time_r;
    served_ticks_nxt = served_ticks_r;
    head_start_nxt   = head_start_r;
    push             = 1'b0;
    out_vld_nxt      = out_vld_r && !out_tready;
    out_kind_nxt     = out_kind_r;
    out_id_nxt       = out_id_r;
    out_start_nxt    = out_start_r;
    out_fin_nxt      = out_fin_r;
    if (fire) begin
      case (in_act_r)
        ACT_ARRIVE: begin
          if (burst_m == '0) begin
            out_vld_nxt   = 1'b1;
            out_kind_nxt  = KIND_ZERO;
            out_id_nxt    = in_id_r;
            out_start_nxt = '0;
            out_fin_nxt   = '0;
          end else if (fill_count_r == CNT_W'(QUEUE_DEPTH)) begin
            out_vld_nxt   = 1'b1;
            out_kind_nxt  = KIND_FULL;
            out_id_nxt    = in_id_r;
            out_start_nxt = '0;
            out_fin_nxt   = '0;
          end else begin
            push           = 1'b1;
            fill_count_nxt = fill_count_r + CNT_W'(1);
            tail_ptr_nxt   = (tail_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : tail_ptr_r + PTR_W'(1);
          end
        end
        default: begin
          if (fill_count_r != '0) begin
            if (served_inc == queued_bursts_r[head_ptr_r]) begin
              out_vld_nxt      = 1'b1;
              out_kind_nxt     = KIND_DONE;
              out_id_nxt       = queued_ids_r[head_ptr_r];
              out_start_nxt    = start_sel;
              out_fin_nxt      = (now_time_r == TIME_MAX) ? TIME_MAX
                                                          : now_time_r + TIME_W'(1);
              head_ptr_nxt     = (head_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : head_ptr_r + PTR_W'(1);
              fill_count_nxt   = fill_count_r - CNT_W'(1);
              served_ticks_nxt = '0;
              head_start_nxt   = start_sel;
            end else begin
              served_ticks_nxt = served_inc;
              head_start_nxt   = start_sel;
            end
          end
          if (now_time_r != TIME_MAX) begin
            now_time_nxt = now_time_r + TIME_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      head_ptr_r     <= '0;
      tail_ptr_r     <= '0;
      fill_count_r   <= '0;
      now_time_r     <= '0;
      served_ticks_r <= '0;
      head_start_r   <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      head_ptr_r     <= head_ptr_nxt;
      tail_ptr_r     <= tail_ptr_nxt;
      fill_count_r   <= fill_count_nxt;
      now_time_r     <= now_time_nxt;
      served_ticks_r <= served_ticks_nxt;
      head_start_r   <= head_start_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_act_r   <= action_t'(in_tuser);
      in_id_r    <= in_tdata[ID_W-1:0];
      in_burst_r <= in_tdata[ID_W+BURST_IN_W-1:ID_W];
    end
    if (push) begin
      queued_ids_r[tail_ptr_r]    <= in_id_r;
      queued_bursts_r[tail_ptr_r] <= burst_m;
    end
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_start_r <= out_start_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_DATA_W'({out_fin_r, out_start_r, out_id_r});

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r == '0) |-> (served_ticks_r == '0 && head_ptr_r == tail_ptr_r))
    else $error("empty queue with service count or pointer mismatch");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r == CNT_W'(QUEUE_DEPTH)) |-> (head_ptr_r == tail_ptr_r))
    else $error("full queue with pointer mismatch");

  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == KIND_DONE) |-> (out_fin_r > out_start_r ||
                                                out_fin_r == TIME_MAX))
    else $error("completion finishes before it starts");

  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (now_time_r >= $past(now_time_r)))
    else $error("time counter went backwards");

endmodule
